>>> rtl/cqs_pkg.sv
// shared types and constants of the circular queue with search
package cqs_pkg;

  // field widths of the stream items
  localparam int MODE_W      = 2;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // capacity register value after reset
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_SRCH = 2'd2
  } mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DEQ  = 2'd2,
    S_SRCH = 2'd3
  } state_t;

  // one result item
  typedef struct packed {
    logic                       found;
    logic signed [VALUE_W-1:0]  data;
    status_t                    status;
  } result_t;

endpackage

>>> rtl/cqs_ram.sv
// generic simple dual-port ram with registered read
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cqs_ctrl.sv
// queue controller: pointers, capacity register, operation sequencer, ram access
module cqs_ctrl #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cqs_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cqs_pkg::MODE_W-1:0]     in_mode,
  input  logic signed [cqs_pkg::VALUE_W-1:0] in_value,
  output logic                           res_valid,
  input  logic                           res_ready,
  output cqs_pkg::result_t               res,
  output logic                           ram_we,
  output logic [$clog2(DEPTH)-1:0]       ram_waddr,
  output logic [WORD_BITS-1:0]           ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(DEPTH)-1:0]       ram_raddr,
  input  logic [WORD_BITS-1:0]           ram_rdata
);
  import cqs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  state_t               state, state_next;
  logic [CFG_W-1:0]     capacity;
  logic [PTR_W-1:0]     head, head_next;
  logic [PTR_W-1:0]     tail, tail_next;
  logic                 is_empty, empty_next;
  logic [PTR_W-1:0]     pos, pos_next;
  logic [MODE_W-1:0]    op_mode;
  logic [WORD_BITS-1:0] op_val;

  logic [CAP_W-1:0]     cap_ext;
  logic [CAP_W-1:0]     eff_cap;
  logic [PTR_W-1:0]     nxt_head, nxt_tail, nxt_pos, stop;
  logic                 hit, last;

  // slot after p, wrapping at the effective capacity
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(p) + CAP_W'(1);
    return (n >= cap) ? '0 : PTR_W'(n);
  endfunction

  // capacity clamped to one .. DEPTH
  assign cap_ext = CAP_W'(capacity);
  assign eff_cap = (cap_ext == '0) ? CAP_W'(1) :
                   (cap_ext > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_ext;

  assign nxt_head = next_slot(head, eff_cap);
  assign nxt_tail = next_slot(tail, eff_cap);
  assign nxt_pos  = next_slot(pos, eff_cap);
  assign stop     = nxt_tail;

  // search step: compare the entry just read, check for end of walk
  assign hit  = (ram_rdata == op_val);
  assign last = (nxt_pos == stop);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (op_mode)
          MODE_DEQ: begin
            if (!is_empty) state_next = S_DEQ;
            else if (res_ready) state_next = S_IDLE;
          end
          MODE_SRCH: begin
            if (!is_empty) state_next = S_SRCH;
            else if (res_ready) state_next = S_IDLE;
          end
          default: begin
            if (res_ready) state_next = S_IDLE;
          end
        endcase
      end
      S_DEQ: begin
        if (res_ready) state_next = S_IDLE;
      end
      S_SRCH: begin
        if ((hit || last) && res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs, ram access and pointer updates
  always_comb begin
    in_ready   = (state == S_IDLE);
    res_valid  = 1'b0;
    res        = '0;
    ram_we     = 1'b0;
    ram_waddr  = tail;
    ram_wdata  = op_val;
    ram_re     = 1'b0;
    ram_raddr  = head;
    head_next  = head;
    tail_next  = tail;
    empty_next = is_empty;
    pos_next   = pos;
    case (state)
      S_EXEC: begin
        case (op_mode)
          MODE_ENQ: begin
            res_valid = 1'b1;
            if (is_empty) begin
              if (res_ready) begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
              end
            end else if (nxt_tail == head) begin
              res.status = ST_OVERFLOW;
            end else if (res_ready) begin
              ram_we    = 1'b1;
              ram_waddr = nxt_tail;
              tail_next = nxt_tail;
            end
          end
          MODE_DEQ: begin
            if (is_empty) begin
              res_valid  = 1'b1;
              res.status = ST_UNDERFLOW;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head;
            end
          end
          MODE_SRCH: begin
            if (is_empty) begin
              res_valid  = 1'b1;
              res.status = ST_UNDERFLOW;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head;
              pos_next  = head;
            end
          end
          default: begin
            // unknown operation: plain ok result, nothing changes
            res_valid = 1'b1;
          end
        endcase
      end
      S_DEQ: begin
        res_valid = 1'b1;
        res.data  = VALUE_W'(ram_rdata);
        if (res_ready) begin
          if (head == tail) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end else begin
            head_next = nxt_head;
          end
        end
      end
      S_SRCH: begin
        if (hit || last) begin
          res_valid = 1'b1;
          res.found = hit;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = nxt_pos;
          pos_next  = nxt_pos;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      is_empty <= 1'b1;
      capacity <= CAP_RESET;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      is_empty <= empty_next;
      if (cfg_we) capacity <= cfg_wdata;
    end
  end

  // operation latch and walk position
  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (in_valid && in_ready) begin
      op_mode <= in_mode;
      op_val  <= WORD_BITS'($unsigned(in_value));
    end
  end

endmodule

>>> rtl/circular_queue_with_search_unit.sv
// top level of the circular queue with search
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata: mode[1:0], value[33:2]
//  m_       | out | m_tvalid/m_tready  | m_tdata: status[1:0], data[33:2], found[34]
//  cfg_     | in  | cfg_we             | cfg_wdata: capacity
//
// enqueue needs no ram read, dequeue does one ram read, search reads the entries
// from head until a match or the newest entry, at most the capacity, one more
// when head was left beyond a lowered capacity;
// the single ram read port, one entry per cycle, sets the search time.
// rst is synchronous: the queue comes up empty with capacity 64, ram contents stay.
// a result waits in the output register; the next item is taken meanwhile and
// stalls only when its own result is ready and the register is still full.
module circular_queue_with_search_unit #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cqs_pkg::CFG_W-1:0]           cfg_wdata,   // capacity
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cqs_pkg::IN_TDATA_W-1:0]      s_tdata,     // mode[1:0], value[33:2]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cqs_pkg::OUT_TDATA_W-1:0]     m_tdata      // status[1:0], data[33:2], found[34]
);
  import cqs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic                 res_valid, res_ready;
  result_t              res, res_q;
  logic                 ram_we, ram_re;
  logic [PTR_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  // sequencer and pointers
  cqs_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tdata[MODE_W-1:0]),
    .in_value  ($signed(s_tdata[MODE_W+VALUE_W-1:MODE_W])),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // queue storage
  cqs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  // result packing, zero fill to whole bytes
  assign m_tdata = {{(OUT_TDATA_W - STATUS_W - VALUE_W - 1){1'b0}},
                    res_q.found, res_q.data, res_q.status};

endmodule
